### hw/rtl/strand_serialized_dispatch_queue_defines.svh
// Assertion macros for the dispatch queue.
`ifndef STRAND_SERIALIZED_DISPATCH_QUEUE_DEFINES_SVH
`define STRAND_SERIALIZED_DISPATCH_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS

`define SDQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define SDQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define SDQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define SDQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### hw/rtl/sdq_pkg.sv
`default_nettype none

package sdq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int NUM_STRANDS = 16;
    localparam int TAG_BITS    = 16;
    localparam int STRAND_BITS = 4;

    localparam logic [1:0] ACT_POST   = 2'd0;
    localparam logic [1:0] ACT_TAKE   = 2'd1;
    localparam logic [1:0] ACT_FINISH = 2'd2;
    localparam logic [1:0] ACT_STOP   = 2'd3;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_FULL       = 3'd1;
    localparam logic [2:0] ST_STOPPED    = 3'd2;
    localparam logic [2:0] ST_BAD_STRAND = 3'd3;
    localparam logic [2:0] ST_NONE_READY = 3'd4;
    localparam logic [2:0] ST_EXIT       = 3'd5;
    localparam logic [2:0] ST_GRANTED    = 3'd6;

    typedef struct packed {
        logic [TAG_BITS-1:0]    tag;
        logic [STRAND_BITS-1:0] strand;
        logic                   has;
    } t_entry;

    function automatic logic strand_ok(input logic [STRAND_BITS-1:0] s);
        return {1'b0, s} < (STRAND_BITS+1)'(NUM_STRANDS);
    endfunction

endpackage

`default_nettype wire

### hw/rtl/sdq_cell.sv
`default_nettype none

module sdq_cell (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [sdq_pkg::NUM_STRANDS-1:0] i_busy,
    input  wire logic                          i_post_en,
    input  wire logic                          i_take_en,
    input  wire sdq_pkg::t_entry               i_post_entry,
    input  wire logic                          i_prev_valid,
    input  wire logic                          i_next_valid,
    input  wire sdq_pkg::t_entry               i_next_entry,
    input  wire logic                          i_found_in,
    input  wire sdq_pkg::t_entry               i_grant_in,
    output logic                               o_valid,
    output sdq_pkg::t_entry                    o_entry,
    output logic                               o_found_out,
    output sdq_pkg::t_entry                    o_grant_out
);
    import sdq_pkg::*;

    logic   r_valid;
    logic   n_valid;
    t_entry r_ent;
    t_entry n_ent;
    logic   w_elig;
    logic   w_sel;

    // idle strand, or no strand at all
    assign w_elig = r_valid &&
        (!r_ent.has || (strand_ok(r_ent.strand) && !i_busy[r_ent.strand]));
    assign w_sel       = w_elig && !i_found_in;
    assign o_found_out = i_found_in || w_elig;
    assign o_grant_out = w_sel ? r_ent : i_grant_in;
    assign o_valid     = r_valid;
    assign o_entry     = r_ent;

    always_comb begin
        n_valid = r_valid;
        n_ent   = r_ent;
        if (i_take_en && o_found_out) begin
            // removal at or below this cell: pull from the younger neighbor
            n_valid = i_next_valid;
            n_ent   = i_next_entry;
        end else if (i_post_en && !r_valid && i_prev_valid) begin
            n_valid = 1'b1;
            n_ent   = i_post_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
    end

endmodule

`default_nettype wire

### hw/rtl/strand_serialized_dispatch_queue.sv
// Strand-serialized task dispatch queue.
// Input channel: i_in_valid / o_in_stall with i_action, i_task_tag, i_strand,
// i_has_strand. Output channel: o_out_valid / i_out_stall with o_status,
// o_wake, o_grant_tag, o_grant_strand, o_grant_has_strand.
// Every input transfer (post, take, finish, stop) gives exactly one result.
// The result sits in the output register the cycle
// after the input transfer. One item per cycle is sustained while the
// receiver takes results; the queue is a row of 16 cells, and a take's
// oldest-eligible search and the shift-down of younger entries both ripple
// through that row within the cycle.
// When the receiver stalls, the held result stays put and o_in_stall rises,
// so no further input is taken until the result is transferred.
// Reset (synchronous, active low) empties the queue, clears all strand busy
// bits, reopens acceptance and drops any pending result.
`default_nettype none
`include "strand_serialized_dispatch_queue_defines.svh"

module strand_serialized_dispatch_queue (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [1:0]                    i_action,
    input  wire logic [sdq_pkg::TAG_BITS-1:0]  i_task_tag,
    input  wire logic [sdq_pkg::STRAND_BITS-1:0] i_strand,
    input  wire logic                          i_has_strand,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [2:0]                         o_status,
    output logic                               o_wake,
    output logic [sdq_pkg::TAG_BITS-1:0]       o_grant_tag,
    output logic [sdq_pkg::STRAND_BITS-1:0]    o_grant_strand,
    output logic                               o_grant_has_strand
);
    import sdq_pkg::*;

    logic                   w_fire;
    logic                   w_post_en;
    logic                   w_take_en;
    t_entry                 w_post_entry;
    logic [QUEUE_DEPTH:0]   w_valid;
    logic [QUEUE_DEPTH-1:0] w_prev;
    t_entry                 w_ent   [0:QUEUE_DEPTH];
    logic [QUEUE_DEPTH:0]   w_found;
    t_entry                 w_grant [0:QUEUE_DEPTH];
    logic                   w_full;
    logic                   w_sok;

    logic [NUM_STRANDS-1:0] r_busy;
    logic [NUM_STRANDS-1:0] n_busy;
    logic                   r_accepting;
    logic                   n_accepting;

    logic                   r_out_valid;
    logic [2:0]             r_status;
    logic [2:0]             n_status;
    logic                   r_wake;
    logic                   n_wake;
    t_entry                 r_grant;
    t_entry                 n_grant;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_fire     = i_in_valid && !o_in_stall;
    assign w_sok      = strand_ok(i_strand);
    assign w_full     = w_valid[QUEUE_DEPTH-1];

    assign w_post_en = w_fire && (i_action == ACT_POST) && r_accepting &&
                       (!i_has_strand || w_sok);
    assign w_take_en = w_fire && (i_action == ACT_TAKE);

    assign w_post_entry.tag    = i_task_tag;
    assign w_post_entry.strand = i_has_strand ? i_strand : '0;
    assign w_post_entry.has    = i_has_strand;

    assign w_valid[QUEUE_DEPTH] = 1'b0;
    assign w_ent[QUEUE_DEPTH]   = '0;
    assign w_found[0]           = 1'b0;
    assign w_grant[0]           = '0;
    assign w_prev = {w_valid[QUEUE_DEPTH-2:0], 1'b1};

    for (genvar gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
        sdq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_busy       (r_busy),
            .i_post_en    (w_post_en),
            .i_take_en    (w_take_en),
            .i_post_entry (w_post_entry),
            .i_prev_valid (w_prev[gi]),
            .i_next_valid (w_valid[gi+1]),
            .i_next_entry (w_ent[gi+1]),
            .i_found_in   (w_found[gi]),
            .i_grant_in   (w_grant[gi]),
            .o_valid      (w_valid[gi]),
            .o_entry      (w_ent[gi]),
            .o_found_out  (w_found[gi+1]),
            .o_grant_out  (w_grant[gi+1])
        );
    end

    always_comb begin
        n_busy      = r_busy;
        n_accepting = r_accepting;
        n_status    = ST_OK;
        n_wake      = 1'b0;
        n_grant     = '0;
        case (i_action)
            ACT_POST: begin
                if (!r_accepting) begin
                    n_status = ST_STOPPED;
                end else if (i_has_strand && !w_sok) begin
                    n_status = ST_BAD_STRAND;
                end else if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_wake = !i_has_strand || !r_busy[i_strand];
                end
            end
            ACT_TAKE: begin
                if (w_found[QUEUE_DEPTH]) begin
                    n_status = ST_GRANTED;
                    n_grant  = w_grant[QUEUE_DEPTH];
                    if (w_grant[QUEUE_DEPTH].has) begin
                        n_busy[w_grant[QUEUE_DEPTH].strand] = 1'b1;
                    end
                end else begin
                    n_status = r_accepting ? ST_NONE_READY : ST_EXIT;
                end
            end
            ACT_FINISH: begin
                if (i_has_strand) begin
                    if (!w_sok) begin
                        n_status = ST_BAD_STRAND;
                    end else begin
                        n_busy[i_strand] = 1'b0;
                    end
                end
            end
            default: begin
                n_accepting = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= '0;
            r_accepting <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_busy      <= n_busy;
                r_accepting <= n_accepting;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_status <= n_status;
            r_wake   <= n_wake;
            r_grant  <= n_grant;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_status           = r_status;
    assign o_wake             = r_wake;
    assign o_grant_tag        = r_grant.tag;
    assign o_grant_strand     = r_grant.strand;
    assign o_grant_has_strand = r_grant.has;

    `SDQ_ASSERT_IMP(a_compact, i_clk, i_rst_n, 1'b1,
        (w_valid[QUEUE_DEPTH-1:0] & QUEUE_DEPTH'(w_valid[QUEUE_DEPTH-1:0] + 1'b1)) == '0)
    `SDQ_ASSERT_NXT(a_stop_sticks, i_clk, i_rst_n, !r_accepting, !r_accepting)
    `SDQ_ASSERT_NXT(a_grant_busy, i_clk, i_rst_n,
        w_take_en && w_found[QUEUE_DEPTH] && w_grant[QUEUE_DEPTH].has,
        r_busy[r_grant.strand] && (r_status == ST_GRANTED))
    `SDQ_ASSERT_NXT(a_post_grows, i_clk, i_rst_n, w_post_en && !w_full,
        w_valid[0] && (r_status == ST_OK))

endmodule

`default_nettype wire
